FILE: hw/rtl/sfq_pkg.sv
// Shared types, codes and defaults for the sortable FIFO queue.
package sfq_pkg;

  localparam int SFQ_DEPTH = 64;
  localparam int SFQ_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_SORT = 2'd2,
    FUNC_DUMP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_SORT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_SORT_DONE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     parity;
  } cell_ctl_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic [5:0]         entry_index;
    logic [6:0]         entry_count;
    logic               is_empty;
    status_t            status;
    logic               last;
  } out_item_t;

endpackage

FILE: hw/rtl/sortable_fifo_queue.sv
// Top level of the sortable FIFO queue built from a chain of storage cells.
//
//   Channel | Ports                          | Moves
//   input   | in_valid, in_stall, in_data    | one operation item (func, push_value)
//   output  | out_valid, out_stall, out_data | result items, last flag on the final one
//
// Push, pop, a sort of fewer than two entries and a dump of an empty queue write one result
// when accepted. A sort runs DEPTH odd-even exchange phases over the cell chain, then writes
// its result from ST_SORT_DONE. A dump, once accepted, rotates the chain once per result.
// Reset clears the entry count and the control state; entry storage is not cleared.
// A two-entry result buffer lets an item be accepted while a result waits; output stalls
// pause a dump and hold off new items once the buffer is full.
module sortable_fifo_queue
  import sfq_pkg::*;
#(
  parameter int DEPTH = SFQ_DEPTH,
  parameter int DATA_WIDTH = SFQ_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t                       state_r;
  state_t                       state_nxt;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_nxt;
  logic [IW-1:0]                step_r;
  logic [IW-1:0]                step_nxt;
  cell_ctl_t                    cell_ctl;
  logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic signed [DATA_WIDTH-1:0] push_ext;
  logic signed [DATA_WIDTH-1:0] newest;
  logic                         in_fire;
  logic                         buf_wr;
  logic                         buf_ready;
  out_item_t                    res;
  logic                         is_full;
  logic                         dump_end;

  assign push_ext = DATA_WIDTH'(in_data.push_value);
  assign newest   = cell_data[IW'(count_r - CW'(1))];
  assign is_full  = count_r == CW'(DEPTH);
  assign dump_end = (CW'(step_r) + CW'(1)) == count_r;
  assign in_stall = (state_r != ST_IDLE) || !buf_ready;
  assign in_fire  = in_valid && !in_stall;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_w;
    logic signed [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_left
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_right
      assign right_w = cell_data[i+1];
    end
    sfq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .ctl(cell_ctl),
      .count(count_r),
      .load_data(push_ext),
      .left_in(left_w),
      .right_in(right_w),
      .head_in(cell_data[0]),
      .data_out(cell_data[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.func == FUNC_SORT) && (count_r >= CW'(2))) begin
            state_nxt = ST_SORT;
          end else if ((in_data.func == FUNC_DUMP) && (count_r != '0)) begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_SORT: begin
        if (step_r == IW'(DEPTH - 1)) state_nxt = ST_SORT_DONE;
      end
      ST_SORT_DONE: begin
        if (buf_ready) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (buf_ready && dump_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_ctl.op     = CELL_HOLD;
    cell_ctl.parity = step_r[0];
    buf_wr          = 1'b0;
    res             = '0;
    res.status      = STAT_OK;
    count_nxt       = count_r;
    step_nxt        = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          unique case (in_data.func)
            FUNC_PUSH: begin
              buf_wr = 1'b1;
              if (is_full) begin
                res.status      = STAT_FULL;
                res.entry_value = 32'(newest);
              end else begin
                cell_ctl.op     = CELL_LOAD;
                count_nxt       = count_r + CW'(1);
                res.entry_value = 32'(push_ext);
              end
            end
            FUNC_POP: begin
              buf_wr = 1'b1;
              if (count_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                cell_ctl.op = CELL_SHIFT;
                count_nxt   = count_r - CW'(1);
                if (count_r > CW'(1)) res.entry_value = 32'(newest);
              end
            end
            FUNC_SORT: begin
              if (count_r < CW'(2)) begin
                buf_wr = 1'b1;
                if (count_r != '0) res.entry_value = 32'(newest);
              end
            end
            FUNC_DUMP: begin
              if (count_r == '0) buf_wr = 1'b1;
            end
            default: buf_wr = 1'b0;
          endcase
          res.entry_count = 7'(count_nxt);
          res.is_empty    = count_nxt == '0;
          res.last        = 1'b1;
        end
      end
      ST_SORT: begin
        cell_ctl.op = CELL_SORT;
        step_nxt    = step_r + IW'(1);
      end
      ST_SORT_DONE: begin
        buf_wr          = 1'b1;
        res.entry_value = 32'(newest);
        res.entry_count = 7'(count_r);
        res.last        = 1'b1;
      end
      ST_DUMP: begin
        if (buf_ready) begin
          buf_wr          = 1'b1;
          cell_ctl.op     = CELL_ROTATE;
          res.entry_value = 32'(cell_data[0]);
          res.entry_index = 6'(step_r);
          res.entry_count = 7'(count_r);
          res.last        = dump_end;
          step_nxt        = step_r + IW'(1);
        end
      end
      default: cell_ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
  end

  sfq_out_buf u_out_buf (
    .clk(clk),
    .rst_n(rst_n),
    .wr_en(buf_wr),
    .wr_data(res),
    .wr_ready(buf_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr |-> buf_ready)
    else $error("Result written into a full output buffer.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.func == FUNC_PUSH) && !is_full)
      |=> count_r == $past(count_r) + CW'(1))
    else $error("Accepted push did not grow the queue by one item.");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT) |=> count_r == $past(count_r))
    else $error("Entry count changed during a sort.");
`endif

endmodule

FILE: hw/rtl/sfq_cell.sv
// One storage cell of the queue chain: load, shift, rotate and compare-exchange.
module sfq_cell
  import sfq_pkg::*;
#(
  parameter int DATA_WIDTH = SFQ_DATA_WIDTH,
  parameter int DEPTH = SFQ_DEPTH,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [CW-1:0]                count,
  input  logic signed [DATA_WIDTH-1:0] load_data,
  input  logic signed [DATA_WIDTH-1:0] left_in,
  input  logic signed [DATA_WIDTH-1:0] right_in,
  input  logic signed [DATA_WIDTH-1:0] head_in,
  output logic signed [DATA_WIDTH-1:0] data_out
);

  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] data_nxt;
  logic                         pair_low;
  logic                         pair_high;
  logic                         below_tail;
  logic                         at_tail;
  logic                         at_count;

  assign below_tail = CW'(INDEX + 1) < count;
  assign at_tail    = CW'(INDEX + 1) == count;
  assign at_count   = CW'(INDEX) == count;
  assign pair_low   = (1'(INDEX % 2) == ctl.parity) && below_tail;
  assign pair_high  = (INDEX >= 1) && (1'((INDEX + 1) % 2) == ctl.parity) &&
                      (CW'(INDEX) < count);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_LOAD: begin
        if (at_count) data_nxt = load_data;
      end
      CELL_SHIFT: data_nxt = right_in;
      CELL_SORT: begin
        if (pair_low && (data_r > right_in)) begin
          data_nxt = right_in;
        end else if (pair_high && (left_in > data_r)) begin
          data_nxt = left_in;
        end
      end
      CELL_ROTATE: begin
        if (at_tail) begin
          data_nxt = head_in;
        end else if (below_tail) begin
          data_nxt = right_in;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

FILE: hw/rtl/sfq_out_buf.sv
// Two-entry result buffer that decouples the queue from output stalls.
module sfq_out_buf
  import sfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_data,
  output logic      wr_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      head_v_r;
  logic      head_v_nxt;
  logic      skid_v_r;
  logic      skid_v_nxt;
  out_item_t head_r;
  out_item_t head_nxt;
  out_item_t skid_r;
  out_item_t skid_nxt;
  logic      pop;

  assign pop = head_v_r && !out_stall;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (!head_v_r || pop) begin
      if (skid_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = skid_r;
        skid_v_nxt = wr_en;
        skid_nxt   = wr_data;
      end else begin
        head_v_nxt = wr_en;
        head_nxt   = wr_data;
      end
    end else if (wr_en) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign wr_ready  = !skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

FILE: dv/tb_sortable_fifo_queue.sv
// Testbench for the sortable FIFO queue: directed and random operations against a queue model.
`timescale 1ns / 1ps

module tb_sortable_fifo_queue;
  import sfq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_OPS = 94;

  class queue_scoreboard;
    logic signed [31:0] held[$];
    out_item_t expected_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_op(in_item_t it);
      out_item_t r;
      logic signed [31:0] t;
      r = '0;
      if (it.func == FUNC_DUMP && held.size() != 0) begin
        foreach (held[i]) begin
          r.entry_value = held[i];
          r.entry_index = 6'(i);
          r.entry_count = 7'(held.size());
          r.is_empty = 1'b0;
          r.status = STAT_OK;
          r.last = (i == held.size() - 1);
          expected_results.push_back(r);
        end
        return;
      end
      r.status = STAT_OK;
      case (it.func)
        FUNC_PUSH: begin
          if (held.size() >= SFQ_DEPTH) r.status = STAT_FULL;
          else held.push_back(it.push_value);
        end
        FUNC_POP: begin
          if (held.size() == 0) r.status = STAT_EMPTY;
          else void'(held.pop_front());
        end
        FUNC_SORT: begin
          for (int i = 0; i + 1 < held.size(); i++) begin
            for (int j = 0; j + 1 < held.size() - i; j++) begin
              if (held[j] > held[j + 1]) begin
                t = held[j];
                held[j] = held[j + 1];
                held[j + 1] = t;
              end
            end
          end
        end
        default: ;
      endcase
      r.entry_value = (held.size() != 0) ? held[$] : '0;
      r.entry_index = '0;
      r.entry_count = 7'(held.size());
      r.is_empty = (held.size() == 0);
      r.last = 1'b1;
      expected_results.push_back(r);
    endfunction

    task check_field(string name, longint got, longint want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_results.pop_front();
      check_field("entry_value", got.entry_value, want.entry_value);
      check_field("entry_index", got.entry_index, want.entry_index);
      check_field("entry_count", got.entry_count, want.entry_count);
      check_field("is_empty", got.is_empty, want.is_empty);
      check_field("status", got.status, want.status);
      check_field("last", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic calm;
  int quiet_cycles = 0;
  queue_scoreboard sb = new();

  sortable_fifo_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic do_op(func_t f, logic signed [31:0] v);
    in_item_t it;
    it.func = f;
    it.push_value = v;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(it);
  endtask

  initial begin
    func_t f;
    logic signed [31:0] v;
    int roll;
    bit filling;
    int edge_hits;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do_op(FUNC_DUMP, $urandom);
    do_op(FUNC_POP, $urandom);
    do_op(FUNC_SORT, $urandom);
    do_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    do_op(FUNC_SORT, $urandom);
    do_op(FUNC_PUSH, 32'sh8000_0000);
    do_op(FUNC_PUSH, -32'sd1);
    do_op(FUNC_PUSH, 32'sd0);
    do_op(FUNC_PUSH, 32'sd1);
    do_op(FUNC_PUSH, 32'sh5555_5555);
    do_op(FUNC_PUSH, 32'shAAAA_AAAA);
    do_op(FUNC_DUMP, $urandom);
    do_op(FUNC_SORT, $urandom);
    do_op(FUNC_DUMP, $urandom);
    do_op(FUNC_POP, $urandom);
    do_op(FUNC_POP, $urandom);
    do_op(FUNC_PUSH, -32'sd1);
    do_op(FUNC_SORT, $urandom);
    do_op(FUNC_DUMP, $urandom);
    repeat (6) do_op(FUNC_POP, $urandom);
    do_op(FUNC_POP, $urandom);

    // Alternate between filling the queue to its limit and draining it empty.
    filling = 1'b1;
    edge_hits = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= 30 && n < 60);
      roll = $urandom_range(0, 99);
      if (filling)
        f = roll < 90 ? FUNC_PUSH : roll < 94 ? FUNC_POP : roll < 97 ? FUNC_SORT : FUNC_DUMP;
      else
        f = roll < 70 ? FUNC_POP : roll < 80 ? FUNC_PUSH : roll < 90 ? FUNC_SORT : FUNC_DUMP;
      case ($urandom_range(0, 9))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2, 3: v = $signed($urandom_range(0, 15)) - 8;
        default: v = $urandom;
      endcase
      do_op(f, v);
      if (filling ? sb.held.size() == SFQ_DEPTH : sb.held.size() == 0) edge_hits++;
      if (edge_hits >= 3) begin
        filling = !filling;
        edge_hits = 0;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SFQ_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_cell.sv
hw/rtl/sfq_out_buf.sv
hw/rtl/sortable_fifo_queue.sv
dv/tb_sortable_fifo_queue.sv
